FILE: rtl/core/c6502_pkg.sv
// ----------------------------------------------------------------------------
// c6502_pkg: shared types and constants of the 6502 execute unit
// Instruction class codes, flag positions and the record passed from the
// front part to the back part.
// ----------------------------------------------------------------------------
package c6502_pkg;

   typedef enum logic [5:0] {
      OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
      OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
      OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11,
      OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
      OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
      OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
      OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27,
      OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31,
      OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35,
      OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
      OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43,
      OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47,
      OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51,
      OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55
   } op_type;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_U = 5;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0]  SP_RESET     = 8'hFD;
   localparam logic [7:0]  STATUS_RESET = 8'h24;
   localparam logic [7:0]  STACK_PAGE   = 8'h01;
   localparam logic        CSR_BRK_VEC  = 1'b0;
   localparam int          QUEUE_DEPTH  = 2;

   // Decoded instruction as the front part hands it to the back part.
   typedef struct packed {
      logic [5:0]  op;
      logic        known;
      logic [7:0]  operand;
      logic        acc_mode;
      logic [15:0] address;
      logic [7:0]  rel_offset;
      logic [15:0] pc_in;
      logic [23:0] stack_read;
      logic        is_branch;
      logic        pen;
   } instr_type;

endpackage

FILE: rtl/core/c6502_front.sv
// ----------------------------------------------------------------------------
// c6502_front: instruction intake and classification
// Accepts decoded instructions, classifies branches and page-penalty
// classes, and holds them in a short queue for the back part.
// ----------------------------------------------------------------------------
module c6502_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [5:0]            req_op,
   input  logic [7:0]            req_operand,
   input  logic                  req_acc_mode,
   input  logic [15:0]           req_address,
   input  logic signed [7:0]     req_rel_offset,
   input  logic [15:0]           req_pc_in,
   input  logic [23:0]           req_stack_read,
   output logic                  q_valid,
   output c6502_pkg::instr_type  q_head,
   input  logic                  q_pop
);
   c6502_pkg::instr_type entry_ff [c6502_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   c6502_pkg::instr_type cls;

   always_comb begin
      cls            = '0;
      cls.op         = req_op;
      cls.known      = (req_op <= 6'(c6502_pkg::OP_TYA));
      cls.operand    = req_operand;
      cls.acc_mode   = req_acc_mode;
      cls.address    = req_address;
      cls.rel_offset = req_rel_offset;
      cls.pc_in      = req_pc_in;
      cls.stack_read = req_stack_read;
      cls.is_branch  = 1'b0;
      cls.pen        = 1'b0;
      unique case (req_op) inside
         c6502_pkg::OP_BCC, c6502_pkg::OP_BCS, c6502_pkg::OP_BEQ,
         c6502_pkg::OP_BMI, c6502_pkg::OP_BNE, c6502_pkg::OP_BPL,
         c6502_pkg::OP_BVC, c6502_pkg::OP_BVS:
            cls.is_branch = 1'b1;
         c6502_pkg::OP_ADC, c6502_pkg::OP_AND, c6502_pkg::OP_CMP,
         c6502_pkg::OP_EOR, c6502_pkg::OP_LDA, c6502_pkg::OP_LDX,
         c6502_pkg::OP_LDY, c6502_pkg::OP_ORA, c6502_pkg::OP_SBC:
            cls.pen = 1'b1;
         default: ;
      endcase
   end

   assign req_stall = (count_ff == 2'(c6502_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end
endmodule

FILE: rtl/core/c6502_back.sv
// ----------------------------------------------------------------------------
// c6502_back: instruction execution and write sequencing
// Executes one queued instruction, updates the architectural registers and
// sends one word per memory write (at least one word per instruction).
// ----------------------------------------------------------------------------
module c6502_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  c6502_pkg::instr_type  q_head,
   output logic                  q_pop,
   input  logic [15:0]           break_vector,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_write_valid,
   output logic [15:0]           rsp_write_address,
   output logic [7:0]            rsp_write_data,
   output logic [15:0]           rsp_new_pc,
   output logic [1:0]            rsp_branch_cycles,
   output logic                  rsp_page_penalty_ok,
   output logic [7:0]            rsp_acc_out,
   output logic [7:0]            rsp_x_out,
   output logic [7:0]            rsp_y_out,
   output logic [7:0]            rsp_status_out,
   output logic [7:0]            rsp_sp_out,
   output logic                  rsp_last
);
   logic [7:0] a_ff, x_ff, y_ff, sp_ff, p_ff;
   logic [7:0] a_in, x_in, y_in, sp_in, p_in;
   logic [1:0] idx_ff, idx_in;

   // Output register
   logic        ov_ff, ov_in;
   logic        owv_ff;
   logic [15:0] owa_ff;
   logic [7:0]  owd_ff;
   logic [15:0] opc_ff;
   logic [1:0]  obc_ff;
   logic        open_ff;
   logic [7:0]  oa_ff, ox_ff, oy_ff, op_ff, osp_ff;
   logic        olast_ff;

   // Execution results
   logic [1:0]  nwr;
   logic [15:0] wa [3];
   logic [7:0]  wd [3];
   logic [15:0] pc_n;
   logic [1:0]  bcyc;
   logic [7:0]  an, xn, yn, spn, pn;
   logic [7:0]  m, src, v;
   logic [8:0]  sum;
   logic        take, cf;
   logic [15:0] ret, tgt;
   logic [7:0]  s0, s1, s2;
   logic        can_load, emit, is_last;

   assign s0 = q_head.stack_read[7:0];
   assign s1 = q_head.stack_read[15:8];
   assign s2 = q_head.stack_read[23:16];

   always_comb begin
      nwr  = 2'd0;
      for (int k = 0; k < 3; k++) begin
         wa[k] = 16'd0;
         wd[k] = 8'd0;
      end
      pc_n = q_head.pc_in;
      an = a_ff; xn = x_ff; yn = y_ff; spn = sp_ff; pn = p_ff;
      m    = q_head.operand;
      src  = q_head.acc_mode ? a_ff : m;
      v    = 8'd0;
      cf   = p_ff[c6502_pkg::FLAG_C];
      sum  = 9'd0;
      take = 1'b0;
      ret  = 16'd0;
      if (q_head.known) begin
         unique case (c6502_pkg::op_type'(q_head.op))
            c6502_pkg::OP_ADC, c6502_pkg::OP_SBC: begin
               v   = (q_head.op == 6'(c6502_pkg::OP_SBC)) ? ~m : m;
               sum = {1'b0, a_ff} + {1'b0, v} + 9'(cf);
               an  = sum[7:0];
               pn[c6502_pkg::FLAG_C] = sum[8];
               pn[c6502_pkg::FLAG_V] = ~(a_ff[7] ^ v[7]) & (a_ff[7] ^ sum[7]);
               v = sum[7:0];
            end
            c6502_pkg::OP_AND: begin an = a_ff & m; v = an; end
            c6502_pkg::OP_EOR: begin an = a_ff ^ m; v = an; end
            c6502_pkg::OP_ORA: begin an = a_ff | m; v = an; end
            c6502_pkg::OP_ASL, c6502_pkg::OP_LSR,
            c6502_pkg::OP_ROL, c6502_pkg::OP_ROR: begin
               unique case (c6502_pkg::op_type'(q_head.op))
                  c6502_pkg::OP_ASL: begin v = {src[6:0], 1'b0}; pn[0] = src[7]; end
                  c6502_pkg::OP_ROL: begin v = {src[6:0], cf};   pn[0] = src[7]; end
                  c6502_pkg::OP_LSR: begin v = {1'b0, src[7:1]}; pn[0] = src[0]; end
                  default:           begin v = {cf, src[7:1]};   pn[0] = src[0]; end
               endcase
               if (q_head.acc_mode) begin
                  an = v;
               end else begin
                  nwr = 2'd1; wa[0] = q_head.address; wd[0] = v;
               end
            end
            c6502_pkg::OP_BCC: take = !p_ff[c6502_pkg::FLAG_C];
            c6502_pkg::OP_BCS: take =  p_ff[c6502_pkg::FLAG_C];
            c6502_pkg::OP_BEQ: take =  p_ff[c6502_pkg::FLAG_Z];
            c6502_pkg::OP_BNE: take = !p_ff[c6502_pkg::FLAG_Z];
            c6502_pkg::OP_BMI: take =  p_ff[c6502_pkg::FLAG_N];
            c6502_pkg::OP_BPL: take = !p_ff[c6502_pkg::FLAG_N];
            c6502_pkg::OP_BVS: take =  p_ff[c6502_pkg::FLAG_V];
            c6502_pkg::OP_BVC: take = !p_ff[c6502_pkg::FLAG_V];
            c6502_pkg::OP_BIT: begin
               pn[7:6] = m[7:6];
               pn[c6502_pkg::FLAG_Z] = ((a_ff & m) == 8'd0);
            end
            c6502_pkg::OP_BRK: begin
               ret = q_head.pc_in + 16'd1;
               nwr = 2'd3;
               wa[0] = {c6502_pkg::STACK_PAGE, sp_ff};          wd[0] = ret[15:8];
               wa[1] = {c6502_pkg::STACK_PAGE, sp_ff - 8'd1};   wd[1] = ret[7:0];
               wa[2] = {c6502_pkg::STACK_PAGE, sp_ff - 8'd2};   wd[2] = p_ff | 8'h30;
               spn = sp_ff - 8'd3;
               pn[c6502_pkg::FLAG_I] = 1'b1;
               pn[c6502_pkg::FLAG_B] = 1'b0;
               pc_n = break_vector;
            end
            c6502_pkg::OP_CLC: pn[c6502_pkg::FLAG_C] = 1'b0;
            c6502_pkg::OP_CLD: pn[c6502_pkg::FLAG_D] = 1'b0;
            c6502_pkg::OP_CLI: pn[c6502_pkg::FLAG_I] = 1'b0;
            c6502_pkg::OP_CLV: pn[c6502_pkg::FLAG_V] = 1'b0;
            c6502_pkg::OP_SEC: pn[c6502_pkg::FLAG_C] = 1'b1;
            c6502_pkg::OP_SED: pn[c6502_pkg::FLAG_D] = 1'b1;
            c6502_pkg::OP_SEI: pn[c6502_pkg::FLAG_I] = 1'b1;
            c6502_pkg::OP_CMP, c6502_pkg::OP_CPX, c6502_pkg::OP_CPY: begin
               src = (q_head.op == 6'(c6502_pkg::OP_CMP)) ? a_ff :
                     (q_head.op == 6'(c6502_pkg::OP_CPX)) ? x_ff : y_ff;
               sum = {1'b0, src} - {1'b0, m};
               v   = sum[7:0];
               pn[c6502_pkg::FLAG_C] = !sum[8];
            end
            c6502_pkg::OP_DEC, c6502_pkg::OP_INC: begin
               v = (q_head.op == 6'(c6502_pkg::OP_DEC)) ? m - 8'd1 : m + 8'd1;
               nwr = 2'd1; wa[0] = q_head.address; wd[0] = v;
            end
            c6502_pkg::OP_DEX: begin xn = x_ff - 8'd1; v = xn; end
            c6502_pkg::OP_DEY: begin yn = y_ff - 8'd1; v = yn; end
            c6502_pkg::OP_INX: begin xn = x_ff + 8'd1; v = xn; end
            c6502_pkg::OP_INY: begin yn = y_ff + 8'd1; v = yn; end
            c6502_pkg::OP_JMP: pc_n = q_head.address;
            c6502_pkg::OP_JSR: begin
               ret = q_head.pc_in - 16'd1;
               nwr = 2'd2;
               wa[0] = {c6502_pkg::STACK_PAGE, sp_ff};        wd[0] = ret[15:8];
               wa[1] = {c6502_pkg::STACK_PAGE, sp_ff - 8'd1}; wd[1] = ret[7:0];
               spn = sp_ff - 8'd2;
               pc_n = q_head.address;
            end
            c6502_pkg::OP_LDA: begin an = m; v = m; end
            c6502_pkg::OP_LDX: begin xn = m; v = m; end
            c6502_pkg::OP_LDY: begin yn = m; v = m; end
            c6502_pkg::OP_NOP: ;
            c6502_pkg::OP_PHA, c6502_pkg::OP_PHP: begin
               nwr = 2'd1;
               wa[0] = {c6502_pkg::STACK_PAGE, sp_ff};
               wd[0] = (q_head.op == 6'(c6502_pkg::OP_PHA)) ? a_ff : (p_ff | 8'h30);
               spn = sp_ff - 8'd1;
            end
            c6502_pkg::OP_PLA: begin spn = sp_ff + 8'd1; an = s0; v = s0; end
            c6502_pkg::OP_PLP: begin
               spn = sp_ff + 8'd1;
               pn = (s0 & 8'hEF) | 8'h20;
            end
            c6502_pkg::OP_RTI: begin
               spn = sp_ff + 8'd3;
               pn = (s0 & 8'hEF) | 8'h20;
               pc_n = {s2, s1};
            end
            c6502_pkg::OP_RTS: begin
               spn = sp_ff + 8'd2;
               pc_n = {s1, s0} + 16'd1;
            end
            c6502_pkg::OP_STA: begin nwr = 2'd1; wa[0] = q_head.address; wd[0] = a_ff; end
            c6502_pkg::OP_STX: begin nwr = 2'd1; wa[0] = q_head.address; wd[0] = x_ff; end
            c6502_pkg::OP_STY: begin nwr = 2'd1; wa[0] = q_head.address; wd[0] = y_ff; end
            c6502_pkg::OP_TAX: begin xn = a_ff; v = a_ff; end
            c6502_pkg::OP_TAY: begin yn = a_ff; v = a_ff; end
            c6502_pkg::OP_TSX: begin xn = sp_ff; v = sp_ff; end
            c6502_pkg::OP_TXA: begin an = x_ff; v = x_ff; end
            c6502_pkg::OP_TXS: spn = x_ff;
            c6502_pkg::OP_TYA: begin an = y_ff; v = y_ff; end
            default: ;
         endcase
         // N and Z follow the value v for the classes listed here; BIT, PLP and RTI set them in their own branches.
         case (c6502_pkg::op_type'(q_head.op)) inside
            c6502_pkg::OP_ADC, c6502_pkg::OP_SBC, c6502_pkg::OP_AND,
            c6502_pkg::OP_EOR, c6502_pkg::OP_ORA, c6502_pkg::OP_ASL,
            c6502_pkg::OP_LSR, c6502_pkg::OP_ROL, c6502_pkg::OP_ROR,
            c6502_pkg::OP_CMP, c6502_pkg::OP_CPX, c6502_pkg::OP_CPY,
            c6502_pkg::OP_DEC, c6502_pkg::OP_INC, c6502_pkg::OP_DEX,
            c6502_pkg::OP_DEY, c6502_pkg::OP_INX, c6502_pkg::OP_INY,
            c6502_pkg::OP_LDA, c6502_pkg::OP_LDX, c6502_pkg::OP_LDY,
            c6502_pkg::OP_PLA, c6502_pkg::OP_TAX, c6502_pkg::OP_TAY,
            c6502_pkg::OP_TSX, c6502_pkg::OP_TXA, c6502_pkg::OP_TYA: begin
               pn[c6502_pkg::FLAG_N] = v[7];
               pn[c6502_pkg::FLAG_Z] = (v == 8'd0);
            end
            default: ;
         endcase
      end
      tgt  = q_head.pc_in + {{8{q_head.rel_offset[7]}}, q_head.rel_offset};
      bcyc = 2'd0;
      if (q_head.is_branch && take) begin
         bcyc = (tgt[15:8] != q_head.pc_in[15:8]) ? 2'd2 : 2'd1;
         pc_n = tgt;
      end
   end

   // One word per write; the instruction retires on its final word.
   assign can_load = !ov_ff || !rsp_stall;
   assign emit     = q_valid && can_load;
   assign is_last  = (nwr == 2'd0) || (idx_ff == nwr - 2'd1);
   assign q_pop    = emit && is_last;

   always_comb begin
      idx_in = idx_ff;
      if (emit) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
      ov_in = emit ? 1'b1 : (rsp_stall ? ov_ff : 1'b0);
      a_in = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff; p_in = p_ff;
      if (q_pop) begin
         a_in = an; x_in = xn; y_in = yn; sp_in = spn; p_in = pn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff   <= 8'd0;
         x_ff   <= 8'd0;
         y_ff   <= 8'd0;
         sp_ff  <= c6502_pkg::SP_RESET;
         p_ff   <= c6502_pkg::STATUS_RESET;
         idx_ff <= 2'd0;
         ov_ff  <= 1'b0;
      end else begin
         a_ff   <= a_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         sp_ff  <= sp_in;
         p_ff   <= p_in;
         idx_ff <= idx_in;
         ov_ff  <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         owv_ff   <= (nwr != 2'd0);
         owa_ff   <= wa[idx_ff];
         owd_ff   <= wd[idx_ff];
         opc_ff   <= pc_n;
         obc_ff   <= bcyc;
         open_ff  <= q_head.pen;
         oa_ff    <= an;
         ox_ff    <= xn;
         oy_ff    <= yn;
         op_ff    <= pn;
         osp_ff   <= spn;
         olast_ff <= is_last;
      end
   end

   assign rsp_valid           = ov_ff;
   assign rsp_write_valid     = owv_ff;
   assign rsp_write_address   = owa_ff;
   assign rsp_write_data      = owd_ff;
   assign rsp_new_pc          = opc_ff;
   assign rsp_branch_cycles   = obc_ff;
   assign rsp_page_penalty_ok = open_ff;
   assign rsp_acc_out         = oa_ff;
   assign rsp_x_out           = ox_ff;
   assign rsp_y_out           = oy_ff;
   assign rsp_status_out      = op_ff;
   assign rsp_sp_out          = osp_ff;
   assign rsp_last            = olast_ff;
endmodule

FILE: rtl/core/cpu6502_execute_unit_core.sv
// ----------------------------------------------------------------------------
// cpu6502_execute_unit_core: 6502 execute stage without decimal mode
// Takes decoded instructions on the req_ channel and returns one rsp_ word
// per memory write the instruction makes (one word if it makes none).
// Each word carries the new PC and a snapshot of A, X, Y, P and S after the
// whole instruction; rsp_last marks the final word of an instruction.
// An instruction is registered in a queue entry, and each of its words in the output register.
// Throughput: one word per cycle unless rsp_stall holds the output, so an
// instruction holds the back part for one word per write (three for BRK, two for JSR), else one.
// A two-entry queue separates intake from execution, so req_stall rises only
// when that queue is full. While rsp_stall is high and a word is valid, that
// word holds and execution pauses; intake continues until the queue fills.
// Reset (synchronous) clears the queue and output, sets A, X, Y to zero, S
// to 0xFD, P to 0x24 and the break vector register to zero.
// The break vector lives at byte address 0 of the psel/paddr port (any paddr with bit 2 clear).
// ----------------------------------------------------------------------------
module cpu6502_execute_unit_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [5:0]         req_op,
   input  logic [7:0]         req_operand,
   input  logic               req_acc_mode,
   input  logic [15:0]        req_address,
   input  logic signed [7:0]  req_rel_offset,
   input  logic [15:0]        req_pc_in,
   input  logic [23:0]        req_stack_read,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_write_valid,
   output logic [15:0]        rsp_write_address,
   output logic [7:0]         rsp_write_data,
   output logic [15:0]        rsp_new_pc,
   output logic [1:0]         rsp_branch_cycles,
   output logic               rsp_page_penalty_ok,
   output logic [7:0]         rsp_acc_out,
   output logic [7:0]         rsp_x_out,
   output logic [7:0]         rsp_y_out,
   output logic [7:0]         rsp_status_out,
   output logic [7:0]         rsp_sp_out,
   output logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   logic [15:0] brk_vec_ff;
   logic        q_valid, q_pop;
   c6502_pkg::instr_type q_head;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == c6502_pkg::CSR_BRK_VEC) ? {16'd0, brk_vec_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         brk_vec_ff <= 16'd0;
      end else if (psel && penable && pwrite && paddr[2] == c6502_pkg::CSR_BRK_VEC) begin
         brk_vec_ff <= pwdata[15:0];
      end
   end

   c6502_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_op, .req_operand,
      .req_acc_mode, .req_address, .req_rel_offset, .req_pc_in, .req_stack_read,
      .q_valid, .q_head, .q_pop
   );

   c6502_back u_back (
      .clock, .reset, .q_valid, .q_head, .q_pop, .break_vector(brk_vec_ff),
      .rsp_valid, .rsp_stall, .rsp_write_valid, .rsp_write_address,
      .rsp_write_data, .rsp_new_pc, .rsp_branch_cycles, .rsp_page_penalty_ok,
      .rsp_acc_out, .rsp_x_out, .rsp_y_out, .rsp_status_out, .rsp_sp_out,
      .rsp_last
   );

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_pc))
      else $error("output word changed under stall");
   a_unused_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status_out[c6502_pkg::FLAG_U] && !rsp_status_out[c6502_pkg::FLAG_B])
      else $error("status word has bad U or B bit");
   a_nowrite_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_valid |-> rsp_last)
      else $error("word without a write is not final");
endmodule
